FILE: rtl/remote_drive_motor_controller_defines.svh
// ----------------------------------------------------------------------------
// Remote drive motor controller assertion macros
// Clocked assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef REMOTE_DRIVE_MOTOR_CONTROLLER_DEFINES_SVH
`define REMOTE_DRIVE_MOTOR_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// Assertion that is off while reset is asserted
`define RMC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion that also holds during reset
`define RMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RMC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/rmc_pkg.sv
// ----------------------------------------------------------------------------
// Remote drive motor controller package
// Shared types, register indexes, reset values and motor level constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rmc_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_DEADBAND       = 3'd0,
        CFG_SLEW_STEP      = 3'd1,
        CFG_DRIVE_SCALE    = 3'd2,
        CFG_FLY_UP_STEP    = 3'd3,
        CFG_FLY_TOP        = 3'd4,
        CFG_FLY_DOWN_STEP  = 3'd5,
        CFG_FLY_IDLE       = 3'd6,
        CFG_FLY_KILL_BELOW = 3'd7
    } cfg_index_t;

    localparam int CFG_W = 7;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_DEADBAND       = 7'd25;
    localparam logic [CFG_W-1:0] RST_SLEW_STEP      = 7'd20;
    localparam logic [CFG_W-1:0] RST_DRIVE_SCALE    = 7'd79;
    localparam logic [CFG_W-1:0] RST_FLY_UP_STEP    = 7'd10;
    localparam logic [CFG_W-1:0] RST_FLY_TOP        = 7'd100;
    localparam logic [CFG_W-1:0] RST_FLY_DOWN_STEP  = 7'd15;
    localparam logic [CFG_W-1:0] RST_FLY_IDLE       = 7'd40;
    localparam logic [CFG_W-1:0] RST_FLY_KILL_BELOW = 7'd50;

    // Stick scaling: |stick| * scale, then divide by 100 via reciprocal
    localparam int                 SCALE_PROD_W  = 15;
    localparam int                 DIV100_FULL_W = 28;
    localparam logic [12:0]        DIV100_RECIP  = 13'd5243;
    localparam int                 DIV100_SHIFT  = 19;

    // Fixed motor levels
    localparam logic signed [7:0]  INTAKE_IN_LEVEL  = 8'sd80;
    localparam logic signed [7:0]  INTAKE_OUT_LEVEL = -8'sd90;
    localparam logic [6:0]         FEEDER_ON_LEVEL  = 7'd100;
    localparam logic signed [7:0]  ARM_UP_LEVEL     = 8'sd100;
    localparam logic signed [7:0]  ARM_DOWN_LEVEL   = -8'sd100;
    localparam logic [6:0]         LEVEL_MAX        = 7'd127;

    // Intake modes
    typedef enum logic [1:0] {
        INTAKE_STOP = 2'd0,
        INTAKE_IN   = 2'd1,
        INTAKE_OUT  = 2'd2
    } intake_mode_t;

    // Scaled stick: sign and magnitude of stick * scale
    typedef struct packed {
        logic                    neg;
        logic [SCALE_PROD_W-1:0] mag;
    } stick_prod_t;

    // Drive path settings
    typedef struct packed {
        logic [CFG_W-1:0] deadband;
        logic [CFG_W-1:0] slew_step;
    } drive_cfg_t;

    // Flywheel settings
    typedef struct packed {
        logic [CFG_W-1:0] up_step;
        logic [CFG_W-1:0] top;
        logic [CFG_W-1:0] down_step;
        logic [CFG_W-1:0] idle;
        logic [CFG_W-1:0] kill_below;
    } fly_cfg_t;

    // Mechanism buttons of one transaction
    typedef struct packed {
        logic fly_a;
        logic fly_b;
        logic kill_a;
        logic kill_b;
        logic intake_in;
        logic intake_out;
        logic feeder;
        logic arm_up;
        logic arm_down;
    } mech_btn_t;

    // Mechanism motor levels
    typedef struct packed {
        logic [6:0] fly_a;
        logic [7:0] fly_b;
        logic [7:0] intake;
        logic [6:0] feeder;
        logic [7:0] arm;
    } mech_out_t;

endpackage

`default_nettype wire

FILE: rtl/rmc_scale.sv
// ----------------------------------------------------------------------------
// Stick scaler
// Splits a stick value into sign and magnitude and multiplies the magnitude
// by the drive scale percent.
// ----------------------------------------------------------------------------
`default_nettype none

module rmc_scale import rmc_pkg::*; (
    input  wire logic signed [7:0]       stick,
    input  wire logic        [CFG_W-1:0] scale,
    output stick_prod_t                  prod
);

    logic [7:0] stick_mag;

    // -128 maps to magnitude 128, which still fits in 8 unsigned bits
    assign stick_mag = stick[7] ? 8'(-stick) : 8'(stick);

    assign prod.neg = stick[7];
    assign prod.mag = SCALE_PROD_W'(stick_mag) * SCALE_PROD_W'(scale);

endmodule

`default_nettype wire

FILE: rtl/rmc_drive.sv
// ----------------------------------------------------------------------------
// Drive path
// Reverse toggle, divide by 100, side swap, saturation, deadband and slew
// limit of both wheels, with the wheel state registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rmc_drive import rmc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step_en,
    input  wire drive_cfg_t         cfg,
    input  wire stick_prod_t        right_prod,
    input  wire stick_prod_t        left_prod,
    input  wire logic               reverse_btn,
    output logic signed [7:0]       right_level_next,
    output logic signed [7:0]       left_level_next
);

    logic              fwd_reg, fwd_next;
    logic              rev_held_reg;
    logic signed [7:0] right_level_reg, left_level_reg;
    stick_prod_t       right_src, left_src;
    logic signed [7:0] right_cmd, left_cmd;

    // Scaled product to saturated signed command
    function automatic logic signed [7:0] to_cmd(stick_prod_t p, logic negate);
        logic [DIV100_FULL_W-1:0] full;
        logic [8:0]               quo;
        logic [6:0]               mag;
        logic                     neg;
        full = DIV100_FULL_W'(p.mag) * DIV100_FULL_W'(DIV100_RECIP);
        quo  = 9'(full >> DIV100_SHIFT);
        mag  = (quo > 9'(LEVEL_MAX)) ? LEVEL_MAX : quo[6:0];
        neg  = p.neg ^ negate;
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // Deadband, then slew limit on outward changes only
    function automatic logic signed [7:0] wheel(logic signed [7:0] cmd,
                                                logic signed [7:0] level,
                                                logic [CFG_W-1:0]  db,
                                                logic [CFG_W-1:0]  st);
        logic signed [9:0] diff;
        logic signed [9:0] lim;
        logic [6:0]        mag;
        logic signed [7:0] res;
        mag  = cmd[7] ? 7'(-cmd) : cmd[6:0];
        diff = 10'(cmd) - 10'(level);
        lim  = $signed({3'b000, st});
        res  = 8'sd0;
        if (mag > db) begin
            if (diff > lim && !cmd[7] && cmd != 8'sd0) begin
                res = 8'(level + $signed({1'b0, st}));
            end else if (diff < -lim && cmd[7]) begin
                res = 8'(level - $signed({1'b0, st}));
            end else begin
                res = cmd;
            end
        end
        return res;
    endfunction

    // Reverse toggle acts on the press edge
    assign fwd_next = fwd_reg ^ (reverse_btn & ~rev_held_reg);

    // Forward: right wheel takes left stick; reversed: own stick, negated
    assign right_src = fwd_next ? left_prod  : right_prod;
    assign left_src  = fwd_next ? right_prod : left_prod;
    assign right_cmd = to_cmd(right_src, ~fwd_next);
    assign left_cmd  = to_cmd(left_src,  ~fwd_next);

    assign right_level_next = wheel(right_cmd, right_level_reg, cfg.deadband, cfg.slew_step);
    assign left_level_next  = wheel(left_cmd,  left_level_reg,  cfg.deadband, cfg.slew_step);

    // Drive state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg         <= 1'b0;
            rev_held_reg    <= 1'b0;
            right_level_reg <= 8'sd0;
            left_level_reg  <= 8'sd0;
        end else if (step_en) begin
            fwd_reg         <= fwd_next;
            rev_held_reg    <= reverse_btn;
            right_level_reg <= right_level_next;
            left_level_reg  <= left_level_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rmc_mech.sv
// ----------------------------------------------------------------------------
// Mechanism control
// Flywheel ramp and kill, intake mode, feeder toggle and arm levels, with
// their toggle state registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rmc_mech import rmc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      step_en,
    input  wire fly_cfg_t  cfg,
    input  wire mech_btn_t btn,
    output mech_out_t      drive
);

    logic         fly_on_reg, fly_on_next;
    logic         fly_held_reg, fly_held_next;
    logic [6:0]   fly_level_reg, fly_level_next;
    logic [6:0]   fly_ramp;
    logic [7:0]   fly_sum;
    intake_mode_t intake_mode_reg, intake_mode_next;
    logic         intake_held_reg;
    logic         feeder_on_reg, feeder_on_next;
    logic         feeder_held_reg;
    logic         fly_both, intake_any;

    assign fly_both   = btn.fly_a & btn.fly_b;
    assign intake_any = btn.intake_in | btn.intake_out;

    // Flywheel toggle; held clears only when both buttons are released
    assign fly_on_next   = fly_on_reg ^ (fly_both & ~fly_held_reg);
    assign fly_held_next = fly_both | (fly_held_reg & (btn.fly_a | btn.fly_b));

    // Flywheel ramp, clamped to 0..127, then the kill
    assign fly_sum = {1'b0, fly_level_reg} + {1'b0, cfg.up_step};
    always_comb begin
        if (fly_on_next && fly_level_reg < cfg.top) begin
            fly_ramp = (fly_sum > 8'(LEVEL_MAX)) ? LEVEL_MAX : fly_sum[6:0];
        end else if (!fly_on_next && fly_level_reg > cfg.idle) begin
            fly_ramp = (fly_level_reg < cfg.down_step) ? 7'd0
                                                       : fly_level_reg - cfg.down_step;
        end else begin
            fly_ramp = fly_level_reg;
        end
        if (btn.kill_a && btn.kill_b && !fly_on_next && fly_ramp < cfg.kill_below) begin
            fly_level_next = 7'd0;
        end else begin
            fly_level_next = fly_ramp;
        end
    end

    // Intake mode: in has priority; any press from a running mode stops
    always_comb begin
        intake_mode_next = intake_mode_reg;
        if (btn.intake_in && !intake_held_reg) begin
            intake_mode_next = (intake_mode_reg == INTAKE_STOP) ? INTAKE_IN : INTAKE_STOP;
        end else if (btn.intake_out && !intake_held_reg) begin
            intake_mode_next = (intake_mode_reg == INTAKE_STOP) ? INTAKE_OUT : INTAKE_STOP;
        end
    end

    // Feeder toggle
    assign feeder_on_next = feeder_on_reg ^ (btn.feeder & ~feeder_held_reg);

    // Motor levels
    always_comb begin
        drive.fly_a  = fly_level_next;
        drive.fly_b  = 8'(-{1'b0, fly_level_next});
        drive.feeder = feeder_on_next ? FEEDER_ON_LEVEL : 7'd0;
        case (intake_mode_next)
            INTAKE_IN:  drive.intake = INTAKE_IN_LEVEL;
            INTAKE_OUT: drive.intake = INTAKE_OUT_LEVEL;
            default:    drive.intake = 8'sd0;
        endcase
        if (btn.arm_up) begin
            drive.arm = ARM_UP_LEVEL;
        end else if (btn.arm_down) begin
            drive.arm = ARM_DOWN_LEVEL;
        end else begin
            drive.arm = 8'sd0;
        end
    end

    // Mechanism state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fly_on_reg      <= 1'b0;
            fly_held_reg    <= 1'b0;
            fly_level_reg   <= 7'd0;
            intake_mode_reg <= INTAKE_STOP;
            intake_held_reg <= 1'b0;
            feeder_on_reg   <= 1'b0;
            feeder_held_reg <= 1'b0;
        end else if (step_en) begin
            fly_on_reg      <= fly_on_next;
            fly_held_reg    <= fly_held_next;
            fly_level_reg   <= fly_level_next;
            intake_mode_reg <= intake_mode_next;
            intake_held_reg <= intake_any;
            feeder_on_reg   <= feeder_on_next;
            feeder_held_reg <= btn.feeder;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/remote_drive_motor_controller.sv
// ----------------------------------------------------------------------------
// Remote drive motor controller
// Turns one remote control tick (two sticks, ten buttons) into seven motor
// levels: two wheels, two flywheel motors, intake, feeder and arm.
// ----------------------------------------------------------------------------
// Usage:
//   s_* is the tick channel (valid/ready), m_* the motor level channel
//   (valid/ready). Each accepted tick yields exactly one result transaction.
//   cfg_we/cfg_index/cfg_wdata write the eight 7-bit settings; write them
//   only while no tick is in flight.
//   Pipeline: input register, scaled-stick register, output register. A
//   result is valid once its tick has been loaded into the output register.
//   Throughput is one tick per cycle unless the receiver stalls; the toggle,
//   level and ramp state is updated as a tick moves into the output register.
//   Reset (aresetn low, synchronous) empties the pipeline, clears all
//   toggles and levels to zero, selects reversed drive mapping and loads
//   the default settings.
//   When the receiver stalls, the result holds in the output register, the
//   two earlier stages keep filling, and s_ready drops once all three are
//   full.
// ----------------------------------------------------------------------------
`default_nettype none
`include "remote_drive_motor_controller_defines.svh"

module remote_drive_motor_controller import rmc_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    // tick channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic signed [7:0] s_right_stick,
    input  wire logic signed [7:0] s_left_stick,
    input  wire logic              s_reverse_btn,
    input  wire logic              s_fly_btn_a,
    input  wire logic              s_fly_btn_b,
    input  wire logic              s_kill_btn_a,
    input  wire logic              s_kill_btn_b,
    input  wire logic              s_intake_in_btn,
    input  wire logic              s_intake_out_btn,
    input  wire logic              s_feeder_btn,
    input  wire logic              s_arm_up_btn,
    input  wire logic              s_arm_down_btn,
    // motor level channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic signed [7:0]      m_right_drive,
    output logic signed [7:0]      m_left_drive,
    output logic        [6:0]      m_fly_drive_a,
    output logic signed [7:0]      m_fly_drive_b,
    output logic signed [7:0]      m_intake_drive,
    output logic        [6:0]      m_feeder_drive,
    output logic signed [7:0]      m_arm_drive
);

    // Settings
    logic [CFG_W-1:0] deadband_reg, slew_step_reg, scale_reg;
    logic [CFG_W-1:0] fly_up_reg, fly_top_reg, fly_down_reg, fly_idle_reg, fly_kill_reg;
    drive_cfg_t       drive_cfg;
    fly_cfg_t         fly_cfg;

    // Pipeline control
    logic v1_reg, v2_reg, m_valid_reg;
    logic adv2, adv_out;

    // Stage 1 payload
    logic signed [7:0] st1_right_stick_reg, st1_left_stick_reg;
    logic              st1_rev_reg;
    mech_btn_t         st1_btn_reg;

    // Stage 2 payload
    stick_prod_t       right_prod, left_prod;
    stick_prod_t       st2_right_prod_reg, st2_left_prod_reg;
    logic              st2_rev_reg;
    mech_btn_t         st2_btn_reg;

    // Results
    logic signed [7:0] right_level_next, left_level_next;
    mech_out_t         mech_drive;
    logic signed [7:0] out_right_reg, out_left_reg;
    mech_out_t         out_mech_reg;

    // Settings register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg  <= RST_DEADBAND;
            slew_step_reg <= RST_SLEW_STEP;
            scale_reg     <= RST_DRIVE_SCALE;
            fly_up_reg    <= RST_FLY_UP_STEP;
            fly_top_reg   <= RST_FLY_TOP;
            fly_down_reg  <= RST_FLY_DOWN_STEP;
            fly_idle_reg  <= RST_FLY_IDLE;
            fly_kill_reg  <= RST_FLY_KILL_BELOW;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DEADBAND:       deadband_reg  <= cfg_wdata;
                CFG_SLEW_STEP:      slew_step_reg <= cfg_wdata;
                CFG_DRIVE_SCALE:    scale_reg     <= cfg_wdata;
                CFG_FLY_UP_STEP:    fly_up_reg    <= cfg_wdata;
                CFG_FLY_TOP:        fly_top_reg   <= cfg_wdata;
                CFG_FLY_DOWN_STEP:  fly_down_reg  <= cfg_wdata;
                CFG_FLY_IDLE:       fly_idle_reg  <= cfg_wdata;
                CFG_FLY_KILL_BELOW: fly_kill_reg  <= cfg_wdata;
            endcase
        end
    end

    assign drive_cfg.deadband   = deadband_reg;
    assign drive_cfg.slew_step  = slew_step_reg;
    assign fly_cfg.up_step      = fly_up_reg;
    assign fly_cfg.top          = fly_top_reg;
    assign fly_cfg.down_step    = fly_down_reg;
    assign fly_cfg.idle         = fly_idle_reg;
    assign fly_cfg.kill_below   = fly_kill_reg;

    // Handshake: each stage moves when the next one is free or moving
    assign adv_out = v2_reg & (~m_valid_reg | m_ready);
    assign adv2    = v1_reg & (~v2_reg | adv_out);
    assign s_ready = ~v1_reg | adv2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                v1_reg <= 1'b1;
            end else if (adv2) begin
                v1_reg <= 1'b0;
            end
            if (adv2) begin
                v2_reg <= 1'b1;
            end else if (adv_out) begin
                v2_reg <= 1'b0;
            end
            if (adv_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Stage 1: capture the tick
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            st1_right_stick_reg    <= s_right_stick;
            st1_left_stick_reg     <= s_left_stick;
            st1_rev_reg            <= s_reverse_btn;
            st1_btn_reg.fly_a      <= s_fly_btn_a;
            st1_btn_reg.fly_b      <= s_fly_btn_b;
            st1_btn_reg.kill_a     <= s_kill_btn_a;
            st1_btn_reg.kill_b     <= s_kill_btn_b;
            st1_btn_reg.intake_in  <= s_intake_in_btn;
            st1_btn_reg.intake_out <= s_intake_out_btn;
            st1_btn_reg.feeder     <= s_feeder_btn;
            st1_btn_reg.arm_up     <= s_arm_up_btn;
            st1_btn_reg.arm_down   <= s_arm_down_btn;
        end
    end

    // Stick times scale
    rmc_scale u_scale_right (
        .stick (st1_right_stick_reg),
        .scale (scale_reg),
        .prod  (right_prod)
    );

    rmc_scale u_scale_left (
        .stick (st1_left_stick_reg),
        .scale (scale_reg),
        .prod  (left_prod)
    );

    // Stage 2: scaled sticks and buttons
    always_ff @(posedge aclk) begin
        if (adv2) begin
            st2_right_prod_reg <= right_prod;
            st2_left_prod_reg  <= left_prod;
            st2_rev_reg        <= st1_rev_reg;
            st2_btn_reg        <= st1_btn_reg;
        end
    end

    // State update and motor levels
    rmc_drive u_drive (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step_en          (adv_out),
        .cfg              (drive_cfg),
        .right_prod       (st2_right_prod_reg),
        .left_prod        (st2_left_prod_reg),
        .reverse_btn      (st2_rev_reg),
        .right_level_next (right_level_next),
        .left_level_next  (left_level_next)
    );

    rmc_mech u_mech (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (adv_out),
        .cfg     (fly_cfg),
        .btn     (st2_btn_reg),
        .drive   (mech_drive)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (adv_out) begin
            out_right_reg <= right_level_next;
            out_left_reg  <= left_level_next;
            out_mech_reg  <= mech_drive;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_right_drive  = out_right_reg;
    assign m_left_drive   = out_left_reg;
    assign m_fly_drive_a  = out_mech_reg.fly_a;
    assign m_fly_drive_b  = $signed(out_mech_reg.fly_b);
    assign m_intake_drive = $signed(out_mech_reg.intake);
    assign m_feeder_drive = out_mech_reg.feeder;
    assign m_arm_drive    = $signed(out_mech_reg.arm);

    // Checks
    `RMC_ASSERT(a_in_capture, aclk, aresetn, (s_valid && s_ready) |=> v1_reg, "accepted transaction not captured")
    `RMC_ASSERT(a_out_load, aclk, aresetn, adv_out |=> m_valid, "state update without result")
    `RMC_ASSERT(a_fly_mirror, aclk, aresetn, m_valid |-> (m_fly_drive_b == -$signed(8'(m_fly_drive_a))), "flywheel motors disagree")
    `RMC_ASSERT(a_intake_code, aclk, aresetn, m_valid |-> (m_intake_drive == INTAKE_IN_LEVEL || m_intake_drive == INTAKE_OUT_LEVEL || m_intake_drive == 8'sd0), "bad intake level")
    `RMC_ASSERT(a_wheel_range, aclk, aresetn, m_valid |-> (m_right_drive != -8'sd128 && m_left_drive != -8'sd128), "wheel level out of range")

endmodule

`default_nettype wire
